@@ rtl/core/irs_pkg.sv @@
// Shared types, constants and helpers for the in-flight request scoreboard.
package irs_pkg;

  localparam int ENTRIES = 8;
  localparam int OUTPUTS = 8;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int FENCE_DEPTH = ENTRIES << SW;

  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_QUEUED   = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_CPL_OUT  = 3'd3;
  localparam logic [2:0] KIND_FAIL     = 3'd4;
  localparam logic [2:0] KIND_FLUSH    = 3'd5;
  localparam logic [2:0] KIND_LOOKUP   = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_REJ  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_REC  = 2'd3;

  localparam logic [2:0] FS_COMPLETED = 3'd2;
  localparam logic [2:0] FS_FAILED    = 3'd3;
  localparam logic [2:0] FS_FLUSHED   = 3'd4;

  localparam logic [15:0] NO_FENCE = 16'hFFFF;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        frame;
    logic [OUTPUTS-1:0] mask;
    logic [SW-1:0]      idx;
    logic               idx_ok;
    logic [15:0]        fence;
    logic [31:0]        tag;
    logic [31:0]        meta;
    logic [31:0]        stime;
  } cmd_t;

  function automatic logic [EW-1:0] low_entry(logic [ENTRIES-1:0] v);
    logic [EW-1:0] r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) r = EW'(i);
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] low_slot(logic [OUTPUTS-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = OUTPUTS - 1; i >= 0; i--) begin
      if (v[i]) r = SW'(i);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/irs_if.sv @@
// Request and response channel interfaces.
interface irs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] frame_key;
  logic [7:0]  output_mask;
  logic [2:0]  slot_index;
  logic [15:0] fence;
  logic [31:0] request_tag;
  logic [31:0] metadata_tag;
  logic [31:0] submit_time;
  modport source (output valid, kind, frame_key, output_mask, slot_index, fence,
                  request_tag, metadata_tag, submit_time, input ready);
  modport sink (input valid, kind, frame_key, output_mask, slot_index, fence,
                request_tag, metadata_tag, submit_time, output ready);
endinterface

interface irs_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] frame_out;
  logic [2:0]  final_state;
  logic [31:0] tag_out;
  logic [31:0] metadata_out;
  logic [31:0] time_out;
  logic [2:0]  slot_out;
  logic        slot_done;
  logic [15:0] slot_fence;
  logic        last;
  logic [3:0]  occupancy;
  modport source (output valid, status, frame_out, final_state, tag_out, metadata_out,
                  time_out, slot_out, slot_done, slot_fence, last, occupancy, input ready);
  modport sink (input valid, status, frame_out, final_state, tag_out, metadata_out,
                time_out, slot_out, slot_done, slot_fence, last, occupancy, output ready);
endinterface

@@ rtl/core/inflight_request_scoreboard_top.sv @@
// Top level of the in-flight request scoreboard.
//
//   channel  dir  payload
//   req      in   kind, frame_key, output_mask, slot_index, fence, tags, submit_time
//   rsp      out  status, frame_out, final_state, tags, slot fields, last, occupancy
//
// A beat waits in the 2-deep front queue, then passes key match and execute before its
// single result is offered; the back end takes a new beat only once the last is finished.
// A retirement instead steps through each entry, then each record row (fence store read, output).
// Reset clears the control state and the valid bits only; table contents are written at start.
// The front keeps accepting while the back waits on rsp.ready, until its queue is full.
module inflight_request_scoreboard_top (
  input  logic      clk,
  input  logic      rst,
  irs_req_if.sink   req,
  irs_rsp_if.source rsp
);
  import irs_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  irs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  irs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule

@@ rtl/core/irs_front.sv @@
// Front end: accepts request beats, classifies them, holds them in a 2-deep queue.
module irs_front (
  input  logic           clk,
  input  logic           rst,
  irs_req_if.sink        req,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output irs_pkg::cmd_t  cmd
);
  import irs_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       cls;

  always_comb begin
    cls.kind   = req.kind;
    cls.frame  = req.frame_key;
    cls.mask   = req.output_mask[OUTPUTS-1:0];
    cls.idx    = req.slot_index[SW-1:0];
    cls.idx_ok = ({1'b0, req.slot_index} < 4'(OUTPUTS));
    cls.fence  = req.fence;
    cls.tag    = req.request_tag;
    cls.meta   = req.metadata_tag;
    cls.stime  = req.submit_time;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/core/irs_back.sv @@
// Back end: request table, key match, operation execution and record sequencing.
module irs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  irs_pkg::cmd_t  cmd,
  irs_rsp_if.source      rsp
);
  import irs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_EXEC = 6'b000100,
    S_NEXT = 6'b001000,
    S_RD   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;

  // table
  logic [ENTRIES-1:0] entry_valid;
  logic [31:0]        entry_frame [ENTRIES];
  logic               entry_phase [ENTRIES];
  logic [31:0]        entry_tag   [ENTRIES];
  logic [31:0]        entry_time  [ENTRIES];
  logic [OUTPUTS-1:0] member_mask [ENTRIES];
  logic [OUTPUTS-1:0] done_mask   [ENTRIES];
  logic [15:0]        fence_mem   [FENCE_DEPTH];
  logic [15:0]        fence_q;

  cmd_t               c;
  logic               hit;
  logic [EW-1:0]      hit_e;
  logic               free_ok;
  logic [EW-1:0]      free_e;
  logic [ENTRIES-1:0] match;

  logic [ENTRIES-1:0] ret_vec;
  logic [EW-1:0]      cur_e;
  logic [OUTPUTS-1:0] rem;
  logic [SW-1:0]      row_slot;
  logic               row_done;
  logic [2:0]         ret_fs;
  logic [31:0]        ret_meta;
  logic [3:0]         occ_after;

  logic [EW-1:0]      rix;
  logic [3:0]         occ;
  logic               out_free;
  logic [OUTPUTS-1:0] slot_bit;
  logic [OUTPUTS-1:0] done_new;
  logic [SW-1:0]      s_pick;
  logic [ENTRIES-1:0] ret_rest;

  // response register
  logic        rv;
  logic [1:0]  r_status;
  logic [31:0] r_frame;
  logic [2:0]  r_fs;
  logic [31:0] r_tag;
  logic [31:0] r_meta;
  logic [31:0] r_time;
  logic [2:0]  r_slot;
  logic        r_done;
  logic [15:0] r_fence;
  logic        r_last;
  logic [3:0]  r_occ;

  assign rsp.valid        = rv;
  assign rsp.status       = r_status;
  assign rsp.frame_out    = r_frame;
  assign rsp.final_state  = r_fs;
  assign rsp.tag_out      = r_tag;
  assign rsp.metadata_out = r_meta;
  assign rsp.time_out     = r_time;
  assign rsp.slot_out     = r_slot;
  assign rsp.slot_done    = r_done;
  assign rsp.slot_fence   = r_fence;
  assign rsp.last         = r_last;
  assign rsp.occupancy    = r_occ;

  assign out_free  = !rv || rsp.ready;
  assign cmd_ready = (state == S_IDLE);
  assign rix       = (state == S_EXEC) ? hit_e : cur_e;
  assign slot_bit  = OUTPUTS'(1) << c.idx;
  assign done_new  = done_mask[rix] | slot_bit;
  assign s_pick    = low_slot(rem);
  assign ret_rest  = ret_vec & ~(ENTRIES'(1) << cur_e);

  always_comb begin
    occ = '0;
    for (int i = 0; i < ENTRIES; i++) occ = occ + 4'(entry_valid[i]);
    for (int i = 0; i < ENTRIES; i++) match[i] = entry_valid[i] && (entry_frame[i] == c.frame);
  end

  // fence store: written on complete-output, read for every record row, used only for slots marked done
  always_ff @(posedge clk) begin
    if (state == S_EXEC && out_free && c.kind == KIND_CPL_OUT && hit && c.idx_ok &&
        member_mask[rix][c.idx])
      fence_mem[{hit_e, c.idx}] <= c.fence;
    if (state == S_RD) fence_q <= fence_mem[{cur_e, s_pick}];
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_valid) c <= cmd;
      end
      S_LOOK: begin
        hit     <= |match;
        hit_e   <= low_entry(match);
        free_ok <= ~&entry_valid;
        free_e  <= low_entry(~entry_valid);
      end
      S_EXEC: begin
        if (out_free) begin
          case (c.kind)
            KIND_START: begin
              if (!hit && c.mask != '0 && free_ok) begin
                entry_frame[free_e] <= c.frame;
                entry_phase[free_e] <= 1'b0;
                entry_tag[free_e]   <= c.tag;
                entry_time[free_e]  <= c.stime;
                member_mask[free_e] <= c.mask;
                done_mask[free_e]   <= '0;
              end
            end
            KIND_QUEUED: begin
              if (hit) entry_phase[hit_e] <= 1'b1;
            end
            KIND_CPL_OUT: begin
              if (hit && c.idx_ok && member_mask[rix][c.idx]) done_mask[hit_e] <= done_new;
            end
            default: ;
          endcase
          ret_meta <= (c.kind == KIND_FAIL || c.kind == KIND_FLUSH) ? 32'd0 : c.meta;
          ret_fs   <= (c.kind == KIND_FAIL) ? FS_FAILED :
                      (c.kind == KIND_FLUSH) ? FS_FLUSHED : FS_COMPLETED;
          occ_after <= (c.kind == KIND_FLUSH) ? 4'd0 : occ - 4'd1;
        end
      end
      S_NEXT: begin
        cur_e <= low_entry(ret_vec);
        rem   <= member_mask[low_entry(ret_vec)];
      end
      S_RD: begin
        row_slot <= s_pick;
        row_done <= done_mask[rix][s_pick];
        rem      <= rem & ~(OUTPUTS'(1) << s_pick);
      end
      default: ;
    endcase
  end

  // response payload
  always_ff @(posedge clk) begin
    if (state == S_EXEC && out_free) begin
      r_status <= ST_REJ;
      r_frame  <= c.frame;
      r_fs     <= '0;
      r_tag    <= '0;
      r_meta   <= '0;
      r_time   <= '0;
      r_slot   <= '0;
      r_done   <= 1'b0;
      r_fence  <= NO_FENCE;
      r_last   <= 1'b1;
      r_occ    <= occ;
      case (c.kind)
        KIND_START: begin
          if (!hit && c.mask != '0 && free_ok) begin
            r_status <= ST_OK;
            r_occ    <= occ + 4'd1;
          end
        end
        KIND_QUEUED: begin
          if (hit && !entry_phase[hit_e]) r_status <= ST_OK;
        end
        KIND_CPL_OUT: begin
          if (hit && c.idx_ok && member_mask[rix][c.idx]) r_status <= ST_WAIT;
        end
        KIND_FLUSH: begin
          r_status <= ST_OK;
          r_frame  <= '0;
        end
        KIND_LOOKUP: begin
          if (hit) r_status <= ST_OK;
        end
        default: ;
      endcase
    end else if (state == S_OUT && out_free) begin
      r_status <= ST_REC;
      r_frame  <= entry_frame[rix];
      r_fs     <= ret_fs;
      r_tag    <= entry_tag[rix];
      r_meta   <= ret_meta;
      r_time   <= entry_time[rix];
      r_slot   <= 3'(row_slot);
      r_done   <= row_done;
      r_fence  <= row_done ? fence_q : NO_FENCE;
      r_last   <= (rem == '0) && (ret_rest == '0);
      r_occ    <= occ_after;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      ret_vec     <= '0;
      rv          <= 1'b0;
    end else begin
      if (rsp.ready) rv <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) state <= S_LOOK;
        end
        S_LOOK: state <= S_EXEC;
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
            rv    <= 1'b1;
            case (c.kind)
              KIND_START: begin
                if (!hit && c.mask != '0 && free_ok)
                  entry_valid[free_e] <= 1'b1;
              end
              KIND_COMPLETE, KIND_FAIL: begin
                if (hit) begin
                  ret_vec            <= ENTRIES'(1) << hit_e;
                  entry_valid[hit_e] <= 1'b0;
                  state              <= S_NEXT;
                  rv                 <= 1'b0;
                end
              end
              KIND_CPL_OUT: begin
                if (hit && c.idx_ok && member_mask[rix][c.idx] &&
                    done_new == member_mask[rix]) begin
                  ret_vec            <= ENTRIES'(1) << hit_e;
                  entry_valid[hit_e] <= 1'b0;
                  state              <= S_NEXT;
                  rv                 <= 1'b0;
                end
              end
              KIND_FLUSH: begin
                if (entry_valid != '0) begin
                  ret_vec     <= entry_valid;
                  entry_valid <= '0;
                  state       <= S_NEXT;
                  rv          <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_NEXT: state <= S_RD;
        S_RD:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            rv <= 1'b1;
            if (rem != '0) begin
              state <= S_RD;
            end else begin
              ret_vec <= ret_rest;
              state   <= (ret_rest == '0) ? S_IDLE : S_NEXT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rd_has_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> rem != '0) else $error("row read with no slot left");

  a_out_entry_live: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> ret_vec[cur_e]) else $error("row for entry not retiring");

  a_rec_state: assert property (@(posedge clk) disable iff (rst)
    rv && r_status == ST_REC |->
      (r_fs == FS_COMPLETED || r_fs == FS_FAILED || r_fs == FS_FLUSHED))
    else $error("record row with bad final state");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rv |-> r_occ <= 4'(ENTRIES)) else $error("occupancy beyond table size");

endmodule

@@ tb/irs_tb_pkg.sv @@
`timescale 1ns / 100ps
// Beat types shared by the scoreboard testbench.
package irs_tb_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] frame_key;
    logic [7:0]  output_mask;
    logic [2:0]  slot_index;
    logic [15:0] fence;
    logic [31:0] request_tag;
    logic [31:0] metadata_tag;
    logic [31:0] submit_time;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] frame_out;
    logic [2:0]  final_state;
    logic [31:0] tag_out;
    logic [31:0] metadata_out;
    logic [31:0] time_out;
    logic [2:0]  slot_out;
    logic        slot_done;
    logic [15:0] slot_fence;
    logic        last;
    logic [3:0]  occupancy;
  } rsp_beat_t;

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the in-flight request scoreboard.
module testbench;
  import irs_pkg::*;
  import irs_tb_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;

  logic clk;
  logic rst;

  irs_req_if req ();
  irs_rsp_if rsp ();

  inflight_request_scoreboard_top uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // shadow table
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_frame [ENTRIES];
  logic        tbl_queued [ENTRIES];
  logic [31:0] tbl_tag [ENTRIES];
  logic [31:0] tbl_time [ENTRIES];
  logic [7:0]  tbl_members [ENTRIES];
  logic [7:0]  tbl_done [ENTRIES];
  logic [15:0] tbl_fence [ENTRIES][8];

  req_beat_t pending_beats[$];
  rsp_beat_t expected_rows[$];
  logic [31:0] live_frames[$];

  int errors = 0;
  int accepted = 0;
  int rows_seen = 0;
  int records_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit long_hold = 0;
  int burst_left = 0;
  int gap_left = 0;

  // set at the rising edge when the current beat got accepted
  logic req_taken = 0;
  int hold_count = 0;
  int phase_count = 0;

  function automatic rsp_beat_t blank_row(logic [1:0] st, logic [31:0] fr);
    rsp_beat_t r;
    r = '0;
    r.status = st;
    r.frame_out = fr;
    r.slot_fence = NO_FENCE;
    return r;
  endfunction

  function automatic int find_frame(logic [31:0] fr);
    for (int e = 0; e < ENTRIES; e++)
      if (tbl_valid[e] && tbl_frame[e] == fr) return e;
    return -1;
  endfunction

  function automatic void retire_entry(int e, logic [2:0] fs, logic [31:0] meta,
                                       ref rsp_beat_t rows[$]);
    rsp_beat_t r;
    for (int s = 0; s < OUTPUTS; s++) begin
      if (tbl_members[e][s]) begin
        r = '0;
        r.status = ST_REC;
        r.frame_out = tbl_frame[e];
        r.final_state = fs;
        r.tag_out = tbl_tag[e];
        r.metadata_out = meta;
        r.time_out = tbl_time[e];
        r.slot_out = 3'(s);
        r.slot_done = tbl_done[e][s];
        r.slot_fence = tbl_fence[e][s];
        rows.insert(rows.size(), r);
      end
    end
    tbl_valid[e] = 0;
  endfunction

  function automatic void predict_beat(req_beat_t b);
    rsp_beat_t rows[$];
    int e;
    int free_e;
    int occ;
    logic [1:0] st;
    logic [31:0] fr;
    logic [7:0] msk;
    st = ST_REJ;
    fr = b.frame_key;
    msk = b.output_mask & 8'((1 << OUTPUTS) - 1);
    e = find_frame(b.frame_key);
    case (b.kind)
      KIND_START: begin
        free_e = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!tbl_valid[i]) free_e = i;
        if (e < 0 && msk != 0 && free_e >= 0) begin
          tbl_valid[free_e] = 1;
          tbl_frame[free_e] = b.frame_key;
          tbl_queued[free_e] = 0;
          tbl_tag[free_e] = b.request_tag;
          tbl_time[free_e] = b.submit_time;
          tbl_members[free_e] = msk;
          tbl_done[free_e] = 0;
          for (int i = 0; i < 8; i++) tbl_fence[free_e][i] = NO_FENCE;
          st = ST_OK;
        end
      end
      KIND_QUEUED: begin
        if (e >= 0 && !tbl_queued[e]) begin
          tbl_queued[e] = 1;
          st = ST_OK;
        end
      end
      KIND_COMPLETE: if (e >= 0) retire_entry(e, FS_COMPLETED, b.metadata_tag, rows);
      KIND_CPL_OUT: begin
        if (e >= 0 && b.slot_index < OUTPUTS && tbl_members[e][b.slot_index]) begin
          tbl_done[e][b.slot_index] = 1;
          tbl_fence[e][b.slot_index] = b.fence;
          if (tbl_done[e] == tbl_members[e])
            retire_entry(e, FS_COMPLETED, b.metadata_tag, rows);
          else
            st = ST_WAIT;
        end
      end
      KIND_FAIL: if (e >= 0) retire_entry(e, FS_FAILED, '0, rows);
      KIND_FLUSH: begin
        for (int i = 0; i < ENTRIES; i++)
          if (tbl_valid[i]) retire_entry(i, FS_FLUSHED, '0, rows);
        if (rows.size() == 0) begin
          st = ST_OK;
          fr = '0;
        end
      end
      KIND_LOOKUP: st = (e >= 0) ? ST_OK : ST_REJ;
      default: ;
    endcase
    if (rows.size() == 0) rows.insert(0, blank_row(st, fr));
    occ = 0;
    for (int i = 0; i < ENTRIES; i++) if (tbl_valid[i]) occ++;
    foreach (rows[i]) begin
      rows[i].occupancy = 4'(occ);
      rows[i].last = (i == rows.size() - 1);
      expected_rows.insert(expected_rows.size(), rows[i]);
    end
  endfunction

  // frame picker biased toward frames that may be live
  function automatic logic [31:0] pick_frame();
    if (live_frames.size() > 0 && $urandom_range(0, 9) < 8)
      return live_frames[$urandom_range(0, live_frames.size() - 1)];
    return $urandom;
  endfunction

  function automatic req_beat_t rand_beat(logic [2:0] k);
    req_beat_t b;
    b.kind = k;
    b.frame_key = pick_frame();
    b.output_mask = $urandom_range(0, 15) == 0 ? 8'h00 : 8'($urandom);
    if ($urandom_range(0, 2) == 0) b.output_mask = 8'(1 << $urandom_range(0, 7));
    b.slot_index = 3'($urandom_range(0, 7));
    b.fence = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 32767));
    b.request_tag = $urandom;
    b.metadata_tag = $urandom;
    b.submit_time = $urandom;
    return b;
  endfunction

  function automatic void add_beat(req_beat_t b);
    if (b.kind == KIND_START) begin
      live_frames.insert(live_frames.size(), b.frame_key);
      if (live_frames.size() > 16) void'(live_frames.pop_front());
    end
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic req_beat_t fixed_beat(logic [2:0] k, logic [31:0] fr, logic [7:0] m,
                                           logic [2:0] ix, logic [15:0] fc);
    req_beat_t b;
    b = '{k, fr, m, ix, fc, 32'hFFFF_FFFF ^ fr, 32'hA5A5_0000 | fr[15:0], fr + 32'd7};
    return b;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // directed part, then random mix
  initial begin
    req_beat_t b;
    add_beat(fixed_beat(KIND_FLUSH, 32'd5, 8'h00, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_START, 32'h0, 8'hFF, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_START, 32'h0, 8'h01, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_START, 32'hFFFF_FFFF, 8'h00, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_START, 32'hFFFF_FFFF, 8'h81, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_QUEUED, 32'hFFFF_FFFF, 8'h0, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_QUEUED, 32'hFFFF_FFFF, 8'h0, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_LOOKUP, 32'h0, 8'h0, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_LOOKUP, 32'h1234, 8'h0, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_CPL_OUT, 32'hFFFF_FFFF, 8'h0, 3'd3, 16'h7FFF));
    add_beat(fixed_beat(KIND_CPL_OUT, 32'hFFFF_FFFF, 8'h0, 3'd7, 16'h7FFF));
    add_beat(fixed_beat(KIND_CPL_OUT, 32'hFFFF_FFFF, 8'h0, 3'd7, 16'hFFFF));
    add_beat(fixed_beat(KIND_CPL_OUT, 32'hFFFF_FFFF, 8'h0, 3'd0, 16'h0000));
    add_beat(fixed_beat(KIND_FAIL, 32'h0, 8'h0, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_COMPLETE, 32'h0, 8'h0, 3'd0, 16'h0));
    for (int i = 0; i < 9; i++)
      add_beat(fixed_beat(KIND_START, 32'h100 + i, 8'(8'h55 << (i % 2)), 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_UNUSED, 32'h100, 8'h0, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_COMPLETE, 32'h101, 8'h0, 3'd0, 16'h0));
    add_beat(fixed_beat(KIND_FLUSH, 32'h0, 8'h0, 3'd0, 16'h0));
    for (int i = 0; i < 225; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:     b = rand_beat(KIND_START);
        5, 6:              b = rand_beat(KIND_QUEUED);
        7:                 b = rand_beat(KIND_COMPLETE);
        8, 9, 10, 11, 12:  b = rand_beat(KIND_CPL_OUT);
        13:                b = rand_beat(KIND_FAIL);
        14:                b = rand_beat($urandom_range(0, 4) == 0 ? KIND_FLUSH : KIND_UNUSED);
        default:           b = rand_beat(KIND_LOOKUP);
      endcase
      add_beat(b);
    end
  end

  initial begin
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  // sender: bursts and gaps, drives at the falling edge
  always @(negedge clk) begin
    req_beat_t b;
    if (rst) begin
      req.valid <= 0;
      req.kind <= '0;
      req.frame_key <= '0;
      req.output_mask <= '0;
      req.slot_index <= '0;
      req.fence <= '0;
      req.request_tag <= '0;
      req.metadata_tag <= '0;
      req.submit_time <= '0;
    end else begin
      if (req.valid && !req_taken) begin
        // hold the current beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req.valid <= 0;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        req.valid <= 1;
        req.kind <= b.kind;
        req.frame_key <= b.frame_key;
        req.output_mask <= b.output_mask;
        req.slot_index <= b.slot_index;
        req.fence <= b.fence;
        req.request_tag <= b.request_tag;
        req.metadata_tag <= b.metadata_tag;
        req.submit_time <= b.submit_time;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req.valid <= 0;
        stim_done <= 1;
      end
    end
  end

  // receiver stall pattern, with one long hold-off early in the random part
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (!long_hold && accepted >= 40) begin
      long_hold <= 1;
      hold_count <= 300;
      rsp.ready <= 0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      rsp.ready <= 0;
    end else begin
      phase_count <= phase_count + 1;
      if ((phase_count / 64) % 3 == 0) rsp.ready <= 1;
      else rsp.ready <= ($urandom_range(0, 9) < 6) || (phase_count % 7 == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_beat_t got;
    rsp_beat_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 0;
      req_taken <= 0;
    end else begin
      req_taken <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        accepted++;
        predict_beat('{req.kind, req.frame_key, req.output_mask, req.slot_index,
                       req.fence, req.request_tag, req.metadata_tag, req.submit_time});
      end
      if (rsp.valid && rsp.ready) begin
        rows_seen++;
        got = '{rsp.status, rsp.frame_out, rsp.final_state, rsp.tag_out, rsp.metadata_out,
                rsp.time_out, rsp.slot_out, rsp.slot_done, rsp.slot_fence, rsp.last,
                rsp.occupancy};
        if (got.status == ST_REC) records_seen++;
        if (expected_rows.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (!rst);
    wait ((stim_done && expected_rows.size() == 0) || idle_cycles >= 5000);
    if (idle_cycles >= 5000) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rows.size());
      $display("status: fail");
      $finish;
    end else begin
      repeat (50) @(posedge clk);
      $display("covered %0d requests, %0d results checked, %0d of them record rows",
               accepted, rows_seen, records_seen);
      if (errors == 0 && expected_rows.size() == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
      $finish;
    end
  end

endmodule
